// File: hdl/adam_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// adam_pkg
// Shared types, constants and the square-root step for the Adam update block.
// ---------------------------------------------------------------------------
package adam_pkg;

    localparam int IDX_W      = 12;
    localparam int DATA_W     = 32;
    localparam int RATE_W     = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int SQRT_STEPS = 32;
    localparam int QUOT_W     = 41;
    localparam int FIFO_DEPTH = 4;
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 48;

    localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_DECAY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_DECAY = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DENOM_FLOOR  = 2'd3;

    localparam logic [31:0]       LEARN_RATE_RST   = 32'd4294967;
    localparam logic [31:0]       FIRST_DECAY_RST  = 32'd3865470566;
    localparam logic [31:0]       SECOND_DECAY_RST = 32'd4290672329;
    localparam logic [15:0]       DENOM_FLOOR_RST  = 16'd1;

    localparam logic [32:0]       ONE_Q32  = 33'h1_0000_0000;
    localparam logic [RATE_W-1:0] RATE_MAX = '1;
    localparam logic [QUOT_W-1:0] STEP_CAP = 41'h100_0000_0000;

    typedef struct packed {
        logic [31:0] learn_rate;
        logic [31:0] first_decay;
        logic [31:0] second_decay;
        logic [15:0] denom_floor;
    } cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] param;
        logic signed [DATA_W-1:0] grad;
        logic [RATE_W-1:0]        rate;
    } item_t;

    typedef struct packed {
        logic [63:0] x;
        logic [63:0] res;
    } sq_t;

    // one digit of the bit-pair square root
    function automatic sq_t sqrt_step(input logic [63:0] x, input logic [63:0] res,
                                      input logic [63:0] bitv);
        sq_t         o;
        logic [64:0] t;
        t = {1'b0, res} + {1'b0, bitv};
        if ({1'b0, x} >= t) begin
            o.x   = x - t[63:0];
            o.res = (res >> 1) + bitv;
        end else begin
            o.x   = x;
            o.res = res >> 1;
        end
        return o;
    endfunction

endpackage
`default_nettype wire

// File: hdl/adam_fifo.sv
`default_nettype none
// ---------------------------------------------------------------------------
// adam_fifo
// Small request queue between the front and the back.
// ---------------------------------------------------------------------------
module adam_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  adam_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output adam_pkg::item_t head_item
);
    import adam_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    item_t         entry_reg [FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   count_reg;

    assign full       = (count_reg == (PW+1)'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= push_item;
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn) push |-> !full)
        else $error("request pushed into full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn) pop |-> head_valid)
        else $error("request popped from empty queue");
`endif

endmodule
`default_nettype wire

// File: hdl/adam_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// adam_front
// Takes input requests, runs the per-pass decay powers and bias-corrected
// rate on a pass start, and tags every request with its rate.
// ---------------------------------------------------------------------------
module adam_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  adam_pkg::cfg_t                     cfg,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [adam_pkg::S_TDATA_W-1:0]     s_tdata,  // idx, param, grad, pad
    input  logic                               s_tuser,  // pass_start
    input  logic                               clear_busy,
    input  logic                               fifo_full,
    output logic                               push,
    output adam_pkg::item_t                    push_item
);
    import adam_pkg::*;

    typedef enum logic [5:0] {
        ST_RUN   = 6'b000001,
        ST_POW   = 6'b000010,
        ST_SQRT  = 6'b000100,
        ST_SCALE = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_PUSH  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [32:0]       p1_reg, p2_reg;
    logic [RATE_W-1:0] rate_reg;
    item_t             hold_reg;
    logic [63:0]       x_reg, res_reg, bit_reg, num_reg, q_reg;
    logic [33:0]       rem_reg;
    logic [5:0]        cnt_reg;
    logic              s_full_reg;

    logic [65:0] pow1_prod, pow2_prod, scale_prod;
    logic [32:0] p1_new, p2_new, c1, c2_new, s_val;
    sq_t         sq;
    logic [33:0] r2;
    logic        div_ge;
    logic [63:0] q_new;
    logic        acc;
    item_t       in_item;

    assign in_item.idx   = s_tdata[11:0];
    assign in_item.param = s_tdata[43:12];
    assign in_item.grad  = s_tdata[75:44];
    assign in_item.rate  = rate_reg;

    assign s_tready = (state_reg == ST_RUN) && !clear_busy && !fifo_full;
    assign acc      = s_tvalid && s_tready;

    assign pow1_prod  = {33'b0, p1_reg} * {34'b0, cfg.first_decay};
    assign pow2_prod  = {33'b0, p2_reg} * {34'b0, cfg.second_decay};
    assign p1_new     = pow1_prod[64:32];
    assign p2_new     = pow2_prod[64:32];
    assign c2_new     = ONE_Q32 - p2_new;
    assign c1         = ONE_Q32 - p1_reg;
    assign sq         = sqrt_step(x_reg, res_reg, bit_reg);
    assign s_val      = s_full_reg ? ONE_Q32 : {1'b0, res_reg[31:0]};
    assign scale_prod = {34'b0, cfg.learn_rate} * {33'b0, s_val};
    assign r2         = {rem_reg[32:0], num_reg[63]};
    assign div_ge     = (r2 >= {1'b0, c1});
    assign q_new      = {q_reg[62:0], div_ge};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN:   if (acc && s_tuser) state_next = ST_POW;
            ST_POW:   state_next = ST_SQRT;
            ST_SQRT:  if (cnt_reg[4:0] == 5'd31) state_next = ST_SCALE;
            ST_SCALE: state_next = ST_DIV;
            ST_DIV:   if (cnt_reg == 6'd63) state_next = ST_PUSH;
            ST_PUSH:  if (!fifo_full) state_next = ST_RUN;
            default:  state_next = ST_RUN;
        endcase
    end

    always_comb begin
        push      = 1'b0;
        push_item = in_item;
        if (state_reg == ST_PUSH) begin
            push      = !fifo_full;
            push_item = hold_reg;
            push_item.rate = rate_reg;
        end else if (acc && !s_tuser) begin
            push = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
            p1_reg    <= ONE_Q32;
            p2_reg    <= ONE_Q32;
            rate_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_POW) begin
                p1_reg <= p1_new;
                p2_reg <= p2_new;
            end
            if (state_reg == ST_DIV && cnt_reg == 6'd63) begin
                rate_reg <= (q_new > 64'(RATE_MAX)) ? RATE_MAX : q_new[RATE_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc && s_tuser) hold_reg <= in_item;
        case (state_reg)
            ST_POW: begin
                x_reg      <= {c2_new[31:0], 32'b0};
                res_reg    <= '0;
                bit_reg    <= 64'(1) << 62;
                s_full_reg <= (p2_new == '0);
                cnt_reg    <= '0;
            end
            ST_SQRT: begin
                x_reg   <= sq.x;
                res_reg <= sq.res;
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 1'b1;
            end
            ST_SCALE: begin
                num_reg <= scale_prod[63:0];
                rem_reg <= '0;
                q_reg   <= '0;
                cnt_reg <= '0;
            end
            ST_DIV: begin
                num_reg <= {num_reg[62:0], 1'b0};
                rem_reg <= div_ge ? (r2 - {1'b0, c1}) : r2;
                q_reg   <= q_new;
                cnt_reg <= cnt_reg + 1'b1;
            end
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    a_push_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PUSH && !fifo_full) |=> (state_reg == ST_RUN))
        else $error("held pass request not released");
`endif

endmodule
`default_nettype wire

// File: hdl/adam_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// adam_back
// Moment store read-modify-write, pipelined square root and divider, and the
// saturating parameter update with an output register.
// ---------------------------------------------------------------------------
module adam_back #(
    parameter int DEPTH = 4096
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  adam_pkg::cfg_t                 cfg,
    input  logic                           head_valid,
    input  adam_pkg::item_t                head_item,
    output logic                           q_pop,
    output logic                           clear_busy,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [adam_pkg::M_TDATA_W-1:0] m_tdata
);
    import adam_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef struct packed {
        item_t it;
        logic  inr;
    } tag_t;

    typedef struct packed {
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] param;
        logic                     inr;
        logic [RATE_W-1:0]        rate;
        logic                     neg;
        logic [31:0]              mag;
    } side_t;

    // moment store
    logic signed [31:0] mem_m [DEPTH];
    logic [63:0]        mem_v [DEPTH];

    logic          clearing_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic          adv, hazard, mem_we, head_inr;
    logic [AW-1:0] head_addr, d_addr;

    // read-modify-write stages
    logic               a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg;
    tag_t               a_tag_reg, b_tag_reg, c_tag_reg, d_tag_reg;
    logic signed [31:0] a_m_reg;
    logic [63:0]        a_v_reg, b_v_reg, b_g2_reg, c_g2_reg, d_g2_reg, d_pl_reg, c_pl_next;
    logic signed [32:0] a_mdiff, b_mdiff_reg;
    logic [31:0]        a_gmag;
    logic [63:0]        a_g2;
    logic signed [65:0] b_pm, c_pm_reg, c_ph, d_ph_reg;
    logic signed [64:0] b_vdiff, c_vdiff_reg;
    logic signed [31:0] c_mnew, d_mnew_reg;
    logic signed [65:0] d_vsum;
    logic [63:0]        d_vnew;

    // square root stages
    logic  e_vld_reg [SQRT_STEPS];
    side_t e_side_reg [SQRT_STEPS];
    sq_t   e_sq_reg [SQRT_STEPS];
    sq_t   e_sq_next [SQRT_STEPS];
    side_t d_side;

    // scale and divide stages
    logic              f_vld_reg, g_vld_reg, h_vld_reg;
    side_t             f_side_reg, g_side_reg, h_side_reg;
    logic [31:0]       f_root_reg;
    logic [32:0]       f_d;
    logic [63:0]       f_plo, g_plo_reg;
    logic [47:0]       f_phi, g_phi_reg;
    logic [48:0]       g_div_reg, h_div_reg;
    logic [79:0]       g_prod, h_prod_reg;
    logic              h_cap;

    logic              k_vld_reg  [QUOT_W];
    side_t             k_side_reg [QUOT_W];
    logic              k_cap_reg  [QUOT_W];
    logic [48:0]       k_div_reg  [QUOT_W];
    logic [48:0]       k_rem_reg  [QUOT_W];
    logic [48:0]       k_rem_next [QUOT_W];
    logic [QUOT_W-1:0] k_low_reg  [QUOT_W];
    logic [QUOT_W-1:0] k_q_reg    [QUOT_W];
    logic [QUOT_W-1:0] k_q_next   [QUOT_W];

    logic [QUOT_W-1:0]  z_q;
    logic signed [42:0] z_sum;
    logic signed [31:0] z_res;
    logic               out_vld_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    assign adv        = !out_vld_reg || m_tready;
    assign clear_busy = clearing_reg;
    assign head_addr  = AW'(head_item.idx);
    assign head_inr   = (21'(head_item.idx) < 21'(DEPTH));
    assign d_addr     = AW'(d_tag_reg.it.idx);

    // items between store read and store write block a request on the same element
    assign hazard = (a_vld_reg && a_tag_reg.it.idx == head_item.idx) ||
                    (b_vld_reg && b_tag_reg.it.idx == head_item.idx) ||
                    (c_vld_reg && c_tag_reg.it.idx == head_item.idx) ||
                    (d_vld_reg && d_tag_reg.it.idx == head_item.idx);
    assign q_pop  = adv && head_valid && !clearing_reg && !hazard;
    assign mem_we = adv && d_vld_reg && d_tag_reg.inr;

    // clearing pass after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clearing_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == AW'(DEPTH - 1)) clearing_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            mem_m[clr_cnt_reg] <= '0;
            mem_v[clr_cnt_reg] <= '0;
        end else if (mem_we) begin
            mem_m[d_addr] <= d_mnew_reg;
            mem_v[d_addr] <= d_vnew;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_m_reg <= mem_m[head_addr];
            a_v_reg <= mem_v[head_addr];
        end
    end

    // moment arithmetic
    assign a_mdiff = {a_m_reg[31], a_m_reg} - {a_tag_reg.it.grad[31], a_tag_reg.it.grad};
    assign a_gmag  = a_tag_reg.it.grad[31] ? 32'(-a_tag_reg.it.grad) : 32'(a_tag_reg.it.grad);
    assign a_g2    = {32'b0, a_gmag} * {32'b0, a_gmag};

    assign b_pm    = $signed({33'b0, cfg.first_decay}) * 66'(b_mdiff_reg);
    assign b_vdiff = $signed({1'b0, b_v_reg}) - $signed({1'b0, b_g2_reg});

    assign c_mnew    = c_tag_reg.it.grad + 32'(c_pm_reg >>> 32);
    assign c_ph      = $signed({33'b0, cfg.second_decay}) * 66'($signed(c_vdiff_reg[64:32]));
    assign c_pl_next = {32'b0, cfg.second_decay} * {32'b0, c_vdiff_reg[31:0]};

    assign d_vsum = $signed({2'b0, d_g2_reg}) + d_ph_reg + $signed({34'b0, d_pl_reg[63:32]});
    assign d_vnew = d_vsum[63:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end else if (adv) begin
            a_vld_reg <= q_pop;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_tag_reg.it  <= head_item;
            a_tag_reg.inr <= head_inr;
            b_tag_reg     <= a_tag_reg;
            b_mdiff_reg   <= a_mdiff;
            b_g2_reg      <= a_g2;
            b_v_reg       <= a_v_reg;
            c_tag_reg     <= b_tag_reg;
            c_pm_reg      <= b_pm;
            c_vdiff_reg   <= b_vdiff;
            c_g2_reg      <= b_g2_reg;
            d_tag_reg     <= c_tag_reg;
            d_mnew_reg    <= c_mnew;
            d_ph_reg      <= c_ph;
            d_pl_reg      <= c_pl_next;
            d_g2_reg      <= c_g2_reg;
        end
    end

    // square root of the new second moment, one digit per stage
    always_comb begin
        d_side.idx   = d_tag_reg.it.idx;
        d_side.param = d_tag_reg.it.param;
        d_side.inr   = d_tag_reg.inr;
        d_side.rate  = d_tag_reg.it.rate;
        d_side.neg   = d_mnew_reg[31];
        d_side.mag   = d_mnew_reg[31] ? 32'(-d_mnew_reg) : 32'(d_mnew_reg);
    end

    always_comb begin
        e_sq_next[0] = sqrt_step(d_vnew, 64'b0, 64'(1) << 62);
        for (int j = 1; j < SQRT_STEPS; j++) begin
            e_sq_next[j] = sqrt_step(e_sq_reg[j-1].x, e_sq_reg[j-1].res,
                                     64'(1) << (62 - 2 * j));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < SQRT_STEPS; j++) e_vld_reg[j] <= 1'b0;
        end else if (adv) begin
            e_vld_reg[0] <= d_vld_reg;
            for (int j = 1; j < SQRT_STEPS; j++) e_vld_reg[j] <= e_vld_reg[j-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e_side_reg[0] <= d_side;
            for (int j = 1; j < SQRT_STEPS; j++) e_side_reg[j] <= e_side_reg[j-1];
            for (int j = 0; j < SQRT_STEPS; j++) e_sq_reg[j] <= e_sq_next[j];
        end
    end

    // denominator and rate * |m|
    always_comb begin
        f_d = 33'(f_root_reg) + 33'(cfg.denom_floor);
        if (f_d == '0) f_d = 33'd1;
    end
    assign f_plo  = {32'b0, f_side_reg.rate[31:0]} * {32'b0, f_side_reg.mag};
    assign f_phi  = {32'b0, f_side_reg.rate[47:32]} * {16'b0, f_side_reg.mag};
    assign g_prod = 80'(g_plo_reg) + (80'(g_phi_reg) << 32);
    assign h_cap  = ({10'b0, h_prod_reg[79:41]} >= h_div_reg);

    // restoring divider, one quotient bit per stage
    always_comb begin
        logic [49:0] r2;
        r2 = {10'b0, h_prod_reg[79:41], h_prod_reg[40]};
        if (r2 >= {1'b0, h_div_reg}) begin
            k_rem_next[0] = 49'(r2 - {1'b0, h_div_reg});
            k_q_next[0]   = QUOT_W'(1);
        end else begin
            k_rem_next[0] = r2[48:0];
            k_q_next[0]   = '0;
        end
        for (int k = 1; k < QUOT_W; k++) begin
            r2 = {k_rem_reg[k-1], k_low_reg[k-1][QUOT_W-1]};
            if (r2 >= {1'b0, k_div_reg[k-1]}) begin
                k_rem_next[k] = 49'(r2 - {1'b0, k_div_reg[k-1]});
                k_q_next[k]   = {k_q_reg[k-1][QUOT_W-2:0], 1'b1};
            end else begin
                k_rem_next[k] = r2[48:0];
                k_q_next[k]   = {k_q_reg[k-1][QUOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
            h_vld_reg <= 1'b0;
            for (int k = 0; k < QUOT_W; k++) k_vld_reg[k] <= 1'b0;
        end else if (adv) begin
            f_vld_reg    <= e_vld_reg[SQRT_STEPS-1];
            g_vld_reg    <= f_vld_reg;
            h_vld_reg    <= g_vld_reg;
            k_vld_reg[0] <= h_vld_reg;
            for (int k = 1; k < QUOT_W; k++) k_vld_reg[k] <= k_vld_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f_side_reg <= e_side_reg[SQRT_STEPS-1];
            f_root_reg <= e_sq_reg[SQRT_STEPS-1].res[31:0];
            g_side_reg <= f_side_reg;
            g_plo_reg  <= f_plo;
            g_phi_reg  <= f_phi;
            g_div_reg  <= {f_d, 16'b0};
            h_side_reg <= g_side_reg;
            h_prod_reg <= g_prod;
            h_div_reg  <= g_div_reg;
            k_side_reg[0] <= h_side_reg;
            k_cap_reg[0]  <= h_cap;
            k_div_reg[0]  <= h_div_reg;
            k_low_reg[0]  <= {h_prod_reg[39:0], 1'b0};
            for (int k = 1; k < QUOT_W; k++) begin
                k_side_reg[k] <= k_side_reg[k-1];
                k_cap_reg[k]  <= k_cap_reg[k-1];
                k_div_reg[k]  <= k_div_reg[k-1];
                k_low_reg[k]  <= {k_low_reg[k-1][QUOT_W-2:0], 1'b0};
            end
            for (int k = 0; k < QUOT_W; k++) begin
                k_rem_reg[k] <= k_rem_next[k];
                k_q_reg[k]   <= k_q_next[k];
            end
        end
    end

    // step cap, signed update and saturation
    always_comb begin
        z_q = k_q_reg[QUOT_W-1];
        if (k_cap_reg[QUOT_W-1] || z_q > STEP_CAP) z_q = STEP_CAP;
        if (k_side_reg[QUOT_W-1].neg)
            z_sum = 43'(k_side_reg[QUOT_W-1].param) + $signed({2'b0, z_q});
        else
            z_sum = 43'(k_side_reg[QUOT_W-1].param) - $signed({2'b0, z_q});
        if (!k_side_reg[QUOT_W-1].inr)   z_res = k_side_reg[QUOT_W-1].param;
        else if (z_sum > 43'sd2147483647)  z_res = 32'sh7FFF_FFFF;
        else if (z_sum < -43'sd2147483648) z_res = 32'sh8000_0000;
        else                               z_res = z_sum[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) out_vld_reg <= 1'b0;
        else if (adv) out_vld_reg <= k_vld_reg[QUOT_W-1];
    end

    always_ff @(posedge aclk) begin
        if (adv) out_data_reg <= {4'b0, z_res, k_side_reg[QUOT_W-1].idx};
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    a_no_pop_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !q_pop)
        else $error("request taken during store clear");
    a_no_write_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (d_vld_reg && d_tag_reg.inr) |-> !clearing_reg)
        else $error("moment write overlaps store clear");
`endif

endmodule
`default_nettype wire

// File: hdl/adam_optimizer_update.sv
`default_nettype none
// ---------------------------------------------------------------------------
// adam_optimizer_update
// Adam weight update for one tensor, streaming one element per request.
// ---------------------------------------------------------------------------
// channel  dir  handshake            payload
// s_       in   s_tvalid/s_tready    tdata: elem_index, param_in, grad_in; tuser: pass_start
// m_       out  m_tvalid/m_tready    tdata: elem_index_out, param_out
// cfg_wr_  in   cfg_wr_en            cfg_wr_idx, cfg_wr_data
//
// One request per cycle when not stalled; the back pipeline is the moment update,
// a 32-stage root and a 41-stage divider. A pass_start request holds the input
// during the power multiply, 32-step root and 64-step rate divide. A request on an
// element still in the moment update waits for its write. After reset the moment
// store is cleared with s_tready low. Back stalls only on m_tready.
// ---------------------------------------------------------------------------
module adam_optimizer_update #(
    parameter int DEPTH = 4096
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [adam_pkg::S_TDATA_W-1:0]    s_tdata,  // elem_index[11:0], param_in[43:12], grad_in[75:44]
    input  logic                              s_tuser,  // pass_start
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [adam_pkg::M_TDATA_W-1:0]    m_tdata,  // elem_index_out[11:0], param_out[43:12]
    input  logic                              cfg_wr_en,
    input  logic [adam_pkg::CFG_IDX_W-1:0]    cfg_wr_idx,
    input  logic [adam_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
    import adam_pkg::*;

    cfg_t  cfg_reg;
    logic  clear_busy, fifo_full, push, pop, head_valid;
    item_t push_item, head_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.learn_rate   <= LEARN_RATE_RST;
            cfg_reg.first_decay  <= FIRST_DECAY_RST;
            cfg_reg.second_decay <= SECOND_DECAY_RST;
            cfg_reg.denom_floor  <= DENOM_FLOOR_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_idx)
                REG_LEARN_RATE:   cfg_reg.learn_rate   <= cfg_wr_data;
                REG_FIRST_DECAY:  cfg_reg.first_decay  <= cfg_wr_data;
                REG_SECOND_DECAY: cfg_reg.second_decay <= cfg_wr_data;
                REG_DENOM_FLOOR:  cfg_reg.denom_floor  <= cfg_wr_data[15:0];
                default: ;
            endcase
        end
    end

    adam_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .clear_busy (clear_busy),
        .fifo_full  (fifo_full),
        .push       (push),
        .push_item  (push_item)
    );

    adam_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    adam_back #(.DEPTH(DEPTH)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .q_pop      (pop),
        .clear_busy (clear_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
`default_nettype wire
